// ----- rtl/go_to_goal_heading_controller_assert.svh -----
// ----------------------------------------------------------------------------
// go_to_goal_heading_controller_assert.svh
// Assertion helper macros for the heading controller. The module that uses
// them must have clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GTG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gtg_pkg.sv -----
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared widths, constants, the arctangent table and the pipeline types of
// the go-to-goal heading controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

  // stage count default and the length of the arctangent table
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  // field widths
  localparam int FW  = 16;              // pose, config and speed fields
  localparam int DW  = FW + 1;          // goal offset
  localparam int FSH = 24;              // pre-scale of the offset
  localparam int XW  = DW + FSH + 3;    // CORDIC x/y, room for gain and negation
  localparam int ZW  = 35;              // angle accumulator, Q2.30 plus headroom
  localparam int AW  = 17;              // angular speed field
  localparam int SQW = 32;              // squared offset per axis

  // angle constants
  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic [FW-1:0]        PI_Q13 = 16'd25736;

  // register indexes on the configuration port
  localparam logic [2:0] REG_GOAL_X    = 3'd0;
  localparam logic [2:0] REG_GOAL_Y    = 3'd1;
  localparam logic [2:0] REG_TURN_GAIN = 3'd2;
  localparam logic [2:0] REG_CRUISE    = 3'd3;
  localparam logic [2:0] REG_ARRIVAL   = 3'd4;
  localparam logic [2:0] REG_STOP      = 3'd5;

  // truncated atan(2^-i) in Q2.30
  function automatic logic [ZW-1:0] atan_q30(input int idx);
    logic [ZW-1:0] v;
    case (idx)
      0:       v = 35'd843314856;
      1:       v = 35'd497837829;
      2:       v = 35'd263043836;
      3:       v = 35'd133525158;
      4:       v = 35'd67021686;
      5:       v = 35'd33543515;
      6:       v = 35'd16775850;
      7:       v = 35'd8388437;
      8:       v = 35'd4194282;
      9:       v = 35'd2097149;
      10:      v = 35'd1048575;
      11:      v = 35'd524287;
      12:      v = 35'd262143;
      13:      v = 35'd131071;
      14:      v = 35'd65535;
      15:      v = 35'd32767;
      16:      v = 35'd16383;
      17:      v = 35'd8191;
      18:      v = 35'd4095;
      19:      v = 35'd2047;
      20:      v = 35'd1023;
      21:      v = 35'd511;
      22:      v = 35'd255;
      23:      v = 35'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // per-item flags that ride along the CORDIC chain
  typedef struct packed {
    logic signed [FW-1:0] hd;
    logic                 zero;
    logic                 arrived;
    logic                 halt;
  } side_t;

  // one CORDIC stage boundary
  typedef struct packed {
    logic                 vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    side_t                side;
  } cdc_t;

endpackage

`default_nettype wire

// ----- rtl/gtg_prep.sv -----
// ----------------------------------------------------------------------------
// gtg_prep
// Front end: goal offset, obstacle test, squared distance against the
// arrival radius and the CORDIC start vector. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_prep
  import gtg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 in_vld,
  input  wire logic signed [FW-1:0] pos_x,
  input  wire logic signed [FW-1:0] pos_y,
  input  wire logic signed [FW-1:0] heading,
  input  wire logic [FW-1:0]        nearest_range,
  input  wire logic                 scan_present,
  input  wire logic signed [FW-1:0] goal_x,
  input  wire logic signed [FW-1:0] goal_y,
  input  wire logic [FW-1:0]        stop_distance,
  input  wire logic [SQW-1:0]       radius_sq,
  output cdc_t                      cdc_o
);

  // stage 1 registers
  logic                 v1_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [FW-1:0] hd1_r;
  logic                 halt1_r;

  // stage 2 registers
  logic                 v2_r;
  logic signed [XW-1:0] x2_r, y2_r;
  logic signed [ZW-1:0] z2_r;
  logic [SQW-1:0]       sqx_r, sqy_r;
  logic signed [FW-1:0] hd2_r;
  logic                 halt2_r, zero2_r;

  logic signed [DW-1:0]    dx_nxt, dy_nxt;
  logic signed [XW-1:0]    xs, ys;
  logic signed [2*DW-1:0]  prod_x, prod_y;
  logic [SQW:0]            sq_sum;

  // offset to goal, exact in 17 bits
  assign dx_nxt = DW'(goal_x) - DW'(pos_x);
  assign dy_nxt = DW'(goal_y) - DW'(pos_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      hd1_r   <= heading;
      halt1_r <= scan_present && (nearest_range <= stop_distance);
    end
  end

  // scaled start vector and per-axis squares
  assign xs     = {{(XW-DW-FSH){dx_r[DW-1]}}, dx_r, {FSH{1'b0}}};
  assign ys     = {{(XW-DW-FSH){dy_r[DW-1]}}, dy_r, {FSH{1'b0}}};
  assign prod_x = (2*DW)'(dx_r) * (2*DW)'(dx_r);
  assign prod_y = (2*DW)'(dy_r) * (2*DW)'(dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // left half-plane: rotate by pi first
      if (dx_r[DW-1]) begin
        x2_r <= -xs;
        y2_r <= -ys;
        z2_r <= dy_r[DW-1] ? -PI_Q30 : PI_Q30;
      end else begin
        x2_r <= xs;
        y2_r <= ys;
        z2_r <= '0;
      end
      sqx_r   <= prod_x[SQW-1:0];
      sqy_r   <= prod_y[SQW-1:0];
      hd2_r   <= hd1_r;
      halt2_r <= halt1_r;
      zero2_r <= (dx_r == '0) && (dy_r == '0);
    end
  end

  // distance test, registered by the first cell
  assign sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_comb begin
    cdc_o.vld          = v2_r;
    cdc_o.x            = x2_r;
    cdc_o.y            = y2_r;
    cdc_o.z            = z2_r;
    cdc_o.side.hd      = hd2_r;
    cdc_o.side.zero    = zero2_r;
    cdc_o.side.halt    = halt2_r;
    cdc_o.side.arrived = sq_sum < {1'b0, radius_sq};
  end

endmodule

`default_nettype wire

// ----- rtl/gtg_cell.sv -----
// ----------------------------------------------------------------------------
// gtg_cell
// One CORDIC vectoring stage: shift-add micro-rotation driven by the sign of
// y, angle accumulation from the table, one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_cell
  import gtg_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire cdc_t cdc_i,
  output cdc_t      cdc_o
);

  localparam logic [ZW-1:0] ATAN_I = atan_q30(STAGE);

  logic signed [XW-1:0] x_i, y_i, xs, ys;
  logic signed [ZW-1:0] z_i;
  cdc_t                 stg_r;

  assign x_i = cdc_i.x;
  assign y_i = cdc_i.y;
  assign z_i = cdc_i.z;
  assign xs  = x_i >>> STAGE;
  assign ys  = y_i >>> STAGE;

  // micro-rotation toward the x axis, valid bit cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else if (adv) begin
      stg_r.vld <= cdc_i.vld;
    end
    if (adv) begin
      if (!y_i[XW-1]) begin
        stg_r.x <= x_i + ys;
        stg_r.y <= y_i - xs;
        stg_r.z <= z_i + $signed(ATAN_I);
      end else begin
        stg_r.x <= x_i - ys;
        stg_r.y <= y_i + xs;
        stg_r.z <= z_i - $signed(ATAN_I);
      end
      stg_r.side <= cdc_i.side;
    end
  end

  assign cdc_o = stg_r;

endmodule

`default_nettype wire

// ----- rtl/gtg_post.sv -----
// ----------------------------------------------------------------------------
// gtg_post
// Back end: bearing rounding and clamp, heading error, gain multiply,
// rounding and saturation of the turn rate, speed overrides and the output
// register. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_post
  import gtg_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire cdc_t           cdc_i,
  input  wire logic [FW-1:0]  turn_gain,
  input  wire logic [FW-1:0]  cruise_speed,
  output logic                out_vld,
  output logic [FW-1:0]       linear_speed,
  output logic [AW-1:0]       angular_speed,
  output logic                arrived,
  output logic                halted
);

  localparam int QW = 18;
  localparam int PW = 34;

  // bearing: round Q2.30 to Q3.13 half away from zero, clamp to +-pi
  logic [ZW-1:0]        zmag, zrnd;
  logic [QW-1:0]        zq;
  logic [FW-1:0]        amag;
  logic signed [AW-1:0] bearing, diff;

  assign zmag    = cdc_i.z[ZW-1] ? ZW'(-cdc_i.z) : ZW'(cdc_i.z);
  assign zrnd    = zmag + (ZW'(1) << 16);
  assign zq      = zrnd[ZW-1:17];
  assign amag    = (zq > QW'(PI_Q13)) ? PI_Q13 : zq[FW-1:0];
  assign bearing = cdc_i.side.zero ? '0 :
                   cdc_i.z[ZW-1]  ? -$signed({1'b0, amag}) : $signed({1'b0, amag});
  assign diff    = bearing - AW'(cdc_i.side.hd);

  logic                 va_r;
  logic signed [AW-1:0] diff_r;
  logic                 arr_a_r, halt_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= cdc_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r   <= diff;
      arr_a_r  <= cdc_i.side.arrived;
      halt_a_r <= cdc_i.side.halt;
    end
  end

  // gain times heading error, Q3.29
  logic signed [PW-1:0] prod;
  logic                 vb_r;
  logic signed [PW-1:0] prod_r;
  logic                 arr_b_r, halt_b_r;

  assign prod = PW'($signed({1'b0, turn_gain})) * PW'(diff_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= prod;
      arr_b_r  <= arr_a_r;
      halt_b_r <= halt_a_r;
    end
  end

  // round to Q3.13, saturate to the 17 bit field, apply the stop overrides
  logic [PW-1:0]  pmag, prnd;
  logic [QW-1:0]  pq, psat;
  logic [QW-1:0]  ang_w;
  logic           neg;

  assign neg   = prod_r[PW-1];
  assign pmag  = neg ? PW'(-prod_r) : PW'(prod_r);
  assign prnd  = pmag + (PW'(1) << 15);
  assign pq    = prnd[PW-1:16];
  assign psat  = neg ? ((pq > (QW'(1) << 16)) ? (QW'(1) << 16) : pq)
                     : ((pq > QW'(17'h0FFFF)) ? QW'(17'h0FFFF) : pq);
  assign ang_w = neg ? -psat : psat;

  logic                 out_vld_r;
  logic [FW-1:0]        lin_r;
  logic [AW-1:0]        ang_r;
  logic                 arr_r, halt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (arr_b_r || halt_b_r) begin
        lin_r <= '0;
        ang_r <= '0;
      end else begin
        lin_r <= cruise_speed;
        ang_r <= ang_w[AW-1:0];
      end
      arr_r  <= arr_b_r;
      halt_r <= halt_b_r;
    end
  end

  assign out_vld       = out_vld_r;
  assign linear_speed  = lin_r;
  assign angular_speed = ang_r;
  assign arrived       = arr_r;
  assign halted        = halt_r;

endmodule

`default_nettype wire

// ----- rtl/go_to_goal_heading_controller.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_heading_controller
// Proportional go-to-goal controller: CORDIC bearing to a configured goal,
// turn rate from the heading error, arrival and obstacle stop.
//
//   channel  direction  handshake            payload
//   in_*     input      in_valid / in_stall  pos_x pos_y heading nearest_range
//                                            scan_present
//   out_*    output     out_valid/out_stall  linear_speed angular_speed
//                                            arrived halted
//   cfg      APB slave  psel penable pwrite  paddr pwdata prdata (pready = 1)
//
// One pose per clock unless the pipeline is frozen; it has two front-end
// stages, one register per CORDIC cell and three back-end stages incl. output.
// The whole pipeline advances together; it freezes only while a result sits
// in the output register with out_stall high, and in_stall follows that.
// Synchronous active-low reset clears valid bits and reloads config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_heading_controller
  import gtg_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // pose input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [FW-1:0] in_pos_x,
  input  wire logic signed [FW-1:0] in_pos_y,
  input  wire logic signed [FW-1:0] in_heading,
  input  wire logic [FW-1:0]        in_nearest_range,
  input  wire logic                 in_scan_present,
  // command output
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [FW-1:0]             out_linear_speed,
  output logic signed [AW-1:0]      out_angular_speed,
  output logic                      out_arrived,
  output logic                      out_halted,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int NSTG = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN :
                        (CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES;

  // configuration registers
  logic signed [FW-1:0] goal_x_r, goal_y_r;
  logic [FW-1:0]        turn_gain_r, cruise_speed_r, arrival_radius_r, stop_distance_r;
  logic [SQW-1:0]       radius_sq_r;
  logic                 wr_en;
  logic [2:0]           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r         <= -16'sd1024;
      goal_y_r         <= -16'sd3712;
      turn_gain_r      <= 16'd13107;
      cruise_speed_r   <= 16'd38;
      arrival_radius_r <= 16'd128;
      stop_distance_r  <= 16'd102;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GOAL_X:    goal_x_r         <= pwdata[FW-1:0];
        REG_GOAL_Y:    goal_y_r         <= pwdata[FW-1:0];
        REG_TURN_GAIN: turn_gain_r      <= pwdata[FW-1:0];
        REG_CRUISE:    cruise_speed_r   <= pwdata[FW-1:0];
        REG_ARRIVAL:   arrival_radius_r <= pwdata[FW-1:0];
        REG_STOP:      stop_distance_r  <= pwdata[FW-1:0];
        default:       ;
      endcase
    end
  end

  // squared arrival radius, registered; settles in the cycle after a write
  always_ff @(posedge clk) begin
    radius_sq_r <= SQW'(arrival_radius_r) * SQW'(arrival_radius_r);
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_GOAL_X:    prdata = 32'(goal_x_r);
      REG_GOAL_Y:    prdata = 32'(goal_y_r);
      REG_TURN_GAIN: prdata = {16'd0, turn_gain_r};
      REG_CRUISE:    prdata = {16'd0, cruise_speed_r};
      REG_ARRIVAL:   prdata = {16'd0, arrival_radius_r};
      REG_STOP:      prdata = {16'd0, stop_distance_r};
      default:       prdata = '0;
    endcase
  end

  // global advance: hold only while the output transaction is stalled
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // front end
  cdc_t chain [NSTG+1];

  gtg_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_vld        (in_valid),
    .pos_x         (in_pos_x),
    .pos_y         (in_pos_y),
    .heading       (in_heading),
    .nearest_range (in_nearest_range),
    .scan_present  (in_scan_present),
    .goal_x        (goal_x_r),
    .goal_y        (goal_y_r),
    .stop_distance (stop_distance_r),
    .radius_sq     (radius_sq_r),
    .cdc_o         (chain[0])
  );

  // CORDIC cell row
  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    gtg_cell #(
      .STAGE (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .cdc_i (chain[g]),
      .cdc_o (chain[g+1])
    );
  end

  // back end and output register
  gtg_post u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .cdc_i         (chain[NSTG]),
    .turn_gain     (turn_gain_r),
    .cruise_speed  (cruise_speed_r),
    .out_vld       (out_valid),
    .linear_speed  (out_linear_speed),
    .angular_speed (out_angular_speed),
    .arrived       (out_arrived),
    .halted        (out_halted)
  );

  // checks
`include "go_to_goal_heading_controller_assert.svh"

  `GTG_ASSERT_IMPLY(a_halt_zero, out_valid && out_halted, (out_linear_speed == '0) && (out_angular_speed == '0), "halted result with nonzero speed")
  `GTG_ASSERT_IMPLY(a_arrive_zero, out_valid && out_arrived, (out_linear_speed == '0) && (out_angular_speed == '0), "arrived result with nonzero speed")
  `GTG_ASSERT_IMPLY(a_stall_src, in_stall, out_valid && out_stall, "input stalled without a held result")
  `GTG_ASSERT_IMPLY(a_cruise, out_valid && !out_arrived && !out_halted, out_linear_speed == cruise_speed_r, "driving speed differs from cruise")

endmodule

`default_nettype wire

// ----- dv/go_to_goal_heading_controller_test.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_heading_controller_test
// Self-checking bench for the go-to-goal heading controller. A short table of
// poses and register writes runs first, then random poses under several goal
// and gain settings and several idle and stall patterns. Each output command
// is checked against its fixed table result or a bit-exact software model of
// the CORDIC bearing, the turn rate, the arrival test and the obstacle stop.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_heading_controller_test
  import gtg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTAGES = CORDIC_STAGES_DEF;
  localparam int LATENCY = NSTAGES + 5;
  localparam int SEG_ITEMS = 125;
  localparam int NUM_SEGS = 8;

  // register index with nothing behind it
  localparam logic [2:0] REG_UNMAPPED = 3'd6;

  // reset values of the goal registers
  localparam int RST_GX = -1024;
  localparam int RST_GY = -3712;

  localparam longint PI_Q30_REF = 64'sd3373259426;
  localparam longint PI_Q13_REF = 64'sd25736;

  // truncated atan(2^-i), Q2.30
  localparam longint ATAN_TBL [0:23] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047,
    1023, 511, 255, 127
  };

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] hd;
    logic [15:0]        rng;
    logic               scan;
  } pose_t;

  typedef struct packed {
    logic [15:0]        lin;
    logic signed [16:0] ang;
    logic               arr;
    logic               hlt;
  } cmd_t;

  // one step of the directed plan: a register write or a pose
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  reg_idx;
    logic [15:0] value;
    pose_t       pose;
    logic        fixed;
    cmd_t        want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic signed [15:0] in_heading = '0;
  logic [15:0]        in_nearest_range = '0;
  logic               in_scan_present = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_linear_speed;
  logic signed [16:0] out_angular_speed;
  logic               out_arrived;
  logic               out_halted;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // model copy of the registers
  logic signed [15:0] goal_x = 16'(RST_GX);
  logic signed [15:0] goal_y = 16'(RST_GY);
  logic [15:0]        turn_gain = 16'd13107;
  logic [15:0]        cruise_speed = 16'd38;
  logic [15:0]        arrival_radius = 16'd128;
  logic [15:0]        stop_distance = 16'd102;

  cmd_t pending_cmds[$];
  plan_row_t plan_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int n_errors = 0;
  int n_poses = 0;
  int n_checked = 0;
  int n_arrived = 0;
  int n_halted = 0;
  int n_cfg = 0;

  go_to_goal_heading_controller u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_heading        (in_heading),
    .in_nearest_range  (in_nearest_range),
    .in_scan_present   (in_scan_present),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_linear_speed  (out_linear_speed),
    .out_angular_speed (out_angular_speed),
    .out_arrived       (out_arrived),
    .out_halted        (out_halted),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Command model
  // ---------------------------------------------------------------------------

  // divide by 2^s, ties away from zero
  function automatic longint round_away(longint v, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  // CORDIC vectoring atan2 of the goal offset, Q3.13
  function automatic longint bearing_q13(longint dx, longint dy);
    longint x, y, z, xs, ys, a;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 64'sd16777216;
    y = dy * 64'sd16777216;
    z = 0;
    if (dx < 0) begin
      z = (dy >= 0) ? PI_Q30_REF : -PI_Q30_REF;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSTAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TBL[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TBL[i];
      end
    end
    a = round_away(z, 17);
    if (a > PI_Q13_REF) a = PI_Q13_REF;
    if (a < -PI_Q13_REF) a = -PI_Q13_REF;
    return a;
  endfunction

  function automatic cmd_t steer_cmd(pose_t p);
    longint dx, dy, d2, r2, ang;
    cmd_t c;
    dx = longint'(goal_x) - longint'(p.px);
    dy = longint'(goal_y) - longint'(p.py);
    d2 = dx * dx + dy * dy;
    r2 = longint'(arrival_radius) * longint'(arrival_radius);
    ang = round_away(longint'(turn_gain) * (bearing_q13(dx, dy) - longint'(p.hd)), 16);
    if (ang > 65535) ang = 65535;
    if (ang < -65536) ang = -65536;
    c.lin = cruise_speed;
    c.arr = (d2 < r2);
    c.hlt = 1'b0;
    if (c.arr) begin
      c.lin = '0;
      ang = 0;
    end
    if (p.scan && p.rng <= stop_distance) begin
      c.lin = '0;
      ang = 0;
      c.hlt = 1'b1;
    end
    c.ang = ang[16:0];
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Plan rows
  // ---------------------------------------------------------------------------

  function automatic plan_row_t pose_row(int px, int py, int hd, int rng, bit scan);
    plan_row_t r;
    r = '0;
    r.pose.px = 16'(px);
    r.pose.py = 16'(py);
    r.pose.hd = 16'(hd);
    r.pose.rng = 16'(rng);
    r.pose.scan = scan;
    return r;
  endfunction

  function automatic plan_row_t fixed_row(int px, int py, int hd, int rng, bit scan,
                                          int lin, int ang, bit arr, bit hlt);
    plan_row_t r;
    r = pose_row(px, py, hd, rng, scan);
    r.fixed = 1'b1;
    r.want.lin = 16'(lin);
    r.want.ang = 17'(ang);
    r.want.arr = arr;
    r.want.hlt = hlt;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [2:0] idx, int value);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.value = 16'(value);
    return r;
  endfunction

  // random pose, biased toward the goal and the stop distance
  function automatic pose_t random_pose();
    pose_t p;
    int r;
    r = int'(arrival_radius);
    if ($urandom_range(99) < 35) begin
      p.px = 16'(int'(goal_x) + int'($urandom_range(0, 2 * r + 8)) - (r + 4));
      p.py = 16'(int'(goal_y) + int'($urandom_range(0, 2 * r + 8)) - (r + 4));
    end else begin
      p.px = 16'($urandom);
      p.py = 16'($urandom);
    end
    if ($urandom_range(99) < 85) p.hd = 16'(int'($urandom_range(0, 51472)) - 25736);
    else p.hd = 16'($urandom);
    if ($urandom_range(99) < 40)
      p.rng = 16'(int'(stop_distance) + int'($urandom_range(0, 4)) - 2);
    else p.rng = 16'($urandom);
    p.scan = ($urandom_range(99) < 70);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  task automatic drive_pose(input pose_t p, input cmd_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_pos_x         <= p.px;
    in_pos_y         <= p.py;
    in_heading       <= p.hd;
    in_nearest_range <= p.rng;
    in_scan_present  <= p.scan;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cmds.push_back(want);
    n_poses++;
  endtask

  // hold off new poses until the pipeline is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // register write, read back for mapped registers, only while idle
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_GOAL_X:    goal_x = val;
      REG_GOAL_Y:    goal_y = val;
      REG_TURN_GAIN: turn_gain = val;
      REG_CRUISE:    cruise_speed = val;
      REG_ARRIVAL:   arrival_radius = val;
      REG_STOP:      stop_distance = val;
      default: ;
    endcase
    n_cfg++;
    if (idx <= REG_STOP) begin
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (prdata[15:0] !== val) begin
        n_errors++;
        $display("%0t: register %0d read-back mismatch, expected %0h, actual %0h",
                 $time, idx, val, prdata[15:0]);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int gx, input int gy, input int gain, input int cruise,
                            input int arr, input int stop);
    write_reg(REG_GOAL_X, 16'(gx));
    write_reg(REG_GOAL_Y, 16'(gy));
    write_reg(REG_TURN_GAIN, 16'(gain));
    write_reg(REG_CRUISE, 16'(cruise));
    write_reg(REG_ARRIVAL, 16'(arr));
    write_reg(REG_STOP, 16'(stop));
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= rst_n && (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // compare each accepted command with the oldest prediction
  always @(posedge clk) begin
    cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        n_errors++;
        $display("%0t: command with no pose outstanding, expected none, actual %0h",
                 $time, {out_linear_speed, out_angular_speed, out_arrived, out_halted});
      end else begin
        want = pending_cmds.pop_front();
        n_checked++;
        if (want.arr) n_arrived++;
        if (want.hlt) n_halted++;
        check_field("linear_speed", want.lin, out_linear_speed);
        check_field("angular_speed", want.ang, out_angular_speed);
        check_field("arrived", want.arr, out_arrived);
        check_field("halted", want.hlt, out_halted);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    pose_t p;

    // directed plan, starting from reset register values
    plan_q.push_back(fixed_row(RST_GX, RST_GY, 0, 16'hFFFF, 1, 0, 0, 1, 0));
    plan_q.push_back(fixed_row(RST_GX, RST_GY, 25736, 0, 1, 0, 0, 1, 1));
    plan_q.push_back(fixed_row(0, 0, 0, 102, 1, 0, 0, 0, 1));
    plan_q.push_back(pose_row(0, 0, 0, 103, 1));
    plan_q.push_back(pose_row(0, 0, 0, 0, 0));
    plan_q.push_back(fixed_row(RST_GX + 127, RST_GY, 0, 16'hFFFF, 0, 0, 0, 1, 0));
    plan_q.push_back(pose_row(RST_GX + 128, RST_GY, 0, 16'hFFFF, 0));
    plan_q.push_back(pose_row(RST_GX - 128, RST_GY, 0, 16'hFFFF, 0));
    plan_q.push_back(pose_row(RST_GX + 512, RST_GY, 0, 16'hFFFF, 0));
    plan_q.push_back(pose_row(RST_GX + 512, RST_GY + 1, 0, 16'hFFFF, 0));
    plan_q.push_back(pose_row(RST_GX, RST_GY - 512, 0, 16'hFFFF, 0));
    plan_q.push_back(pose_row(RST_GX, RST_GY + 512, 0, 16'hFFFF, 0));
    plan_q.push_back(pose_row(32767, 32767, 25736, 65535, 1));
    plan_q.push_back(pose_row(-32768, -32768, -25736, 0, 0));
    plan_q.push_back(pose_row(32767, -32768, 32767, 65535, 0));
    plan_q.push_back(pose_row(-32768, 32767, -32768, 0, 0));
    plan_q.push_back(cfg_row(REG_TURN_GAIN, 65535));
    plan_q.push_back(pose_row(RST_GX + 512, RST_GY, -32768, 16'hFFFF, 0));
    plan_q.push_back(pose_row(RST_GX + 512, RST_GY + 1, 32767, 16'hFFFF, 0));
    plan_q.push_back(cfg_row(REG_TURN_GAIN, 0));
    plan_q.push_back(fixed_row(0, 0, 25736, 16'hFFFF, 0, 38, 0, 0, 0));
    // a write past the last register must change nothing
    plan_q.push_back(cfg_row(REG_UNMAPPED, 16'hFFFF));
    plan_q.push_back(fixed_row(0, 0, -25736, 16'hFFFF, 1, 38, 0, 0, 0));
    plan_q.push_back(cfg_row(REG_ARRIVAL, 0));
    plan_q.push_back(fixed_row(RST_GX, RST_GY, 0, 16'hFFFF, 0, 38, 0, 0, 0));

    // reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) write_reg(plan_q[i].reg_idx, plan_q[i].value);
      else drive_pose(plan_q[i].pose,
                      plan_q[i].fixed ? plan_q[i].want : steer_cmd(plan_q[i].pose));
    end

    // random segments, each with its own registers and an idle and stall pattern
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        1: set_config(32767, 32767, 65535, 65535, 0, 0);
        2: set_config(-32768, -32768, 0, 0, 65535, 65535);
        default: begin
          if ($urandom_range(1)) set_config($urandom, $urandom, $urandom, $urandom,
                                            $urandom_range(0, 2048), $urandom_range(0, 1024));
          else set_config(int'($urandom_range(0, 4096)) - 2048,
                          int'($urandom_range(0, 4096)) - 2048, $urandom, $urandom,
                          $urandom_range(0, 512), $urandom_range(0, 256));
        end
      endcase
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      for (int k = 0; k < SEG_ITEMS; k++) begin
        // let the pipeline run dry once per segment
        if (k == SEG_ITEMS / 2) wait_drained();
        p = random_pose();
        drive_pose(p, steer_cmd(p));
      end
    end

    wait_drained();
    $display("Ran %0d poses through %0d register writes, %0d commands compared",
             n_poses, n_cfg, n_checked);
    $display("Commands with arrival: %0d, with obstacle stop: %0d", n_arrived, n_halted);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- go_to_goal_heading_controller.f -----
+incdir+rtl
rtl/gtg_pkg.sv
rtl/gtg_prep.sv
rtl/gtg_cell.sv
rtl/gtg_post.sv
rtl/go_to_goal_heading_controller.sv
dv/go_to_goal_heading_controller_test.sv
